### hdl/bmp8_pkg.sv
// Package for the 8-bit palettised BMP decoder.
// Holds the transaction structs, operation and error codes and fixed sizes.
// No dependencies.
package bmp8_pkg;

    localparam int MaxWidthDef   = 4096;
    localparam int MaxHeightDef  = 4096;
    localparam int PaletteDef    = 256;
    localparam int HeaderBytes   = 54;

    localparam logic [31:0] OFF_SIG    = 32'd1;
    localparam logic [31:0] OFF_DATA   = 32'd13;
    localparam logic [31:0] OFF_HSIZE  = 32'd17;
    localparam logic [31:0] OFF_WIDTH  = 32'd21;
    localparam logic [31:0] OFF_HEIGHT = 32'd25;
    localparam logic [31:0] OFF_PLANES = 32'd27;
    localparam logic [31:0] OFF_DEPTH  = 32'd29;
    localparam logic [31:0] OFF_COMP   = 32'd33;
    localparam logic [31:0] OFF_ISIZE  = 32'd37;
    localparam logic [31:0] OFF_COLORS = 32'd49;
    localparam logic [31:0] OFF_LAST   = 32'd53;

    localparam logic [15:0] SIG_BM     = 16'h4D42;
    localparam logic [31:0] INFO_SIZE  = 32'd40;

    localparam logic [2:0] ERR_SIG    = 3'd0;
    localparam logic [2:0] ERR_HSIZE  = 3'd1;
    localparam logic [2:0] ERR_PLANES = 3'd2;
    localparam logic [2:0] ERR_DEPTH  = 3'd3;
    localparam logic [2:0] ERR_COMP   = 3'd4;
    localparam logic [2:0] ERR_ISIZE  = 3'd5;
    localparam logic [2:0] ERR_BOUNDS = 3'd6;

    localparam logic [0:0] KIND_PIXEL = 1'b0;
    localparam logic [0:0] KIND_ERROR = 1'b1;

    localparam logic [2:0] REG_TRANSP = 3'd0;

    typedef enum logic [1:0] {
        OP_WR  = 2'd0,
        OP_PIX = 2'd1,
        OP_ERR = 2'd2
    } t_opkind;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  error_code;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } t_out;

    typedef struct packed {
        t_opkind     kind;
        logic [7:0]  idx;
        logic [23:0] color;
        logic        loaded;
        logic [2:0]  err;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  alpha;
        logic        last;
    } t_op;

endpackage

### hdl/bmp8_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmp8_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/bmp8_queue.sv
// Two-entry operation queue between the parser and the pixel back end.
// Depends on bmp8_pkg.
module bmp8_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bmp8_pkg::t_op i_data,
    output logic          o_full,
    output logic          o_valid,
    output bmp8_pkg::t_op o_data,
    input  logic          i_pop
);
    bmp8_pkg::t_op r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_buf[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];
endmodule

### hdl/bmp8_front.sv
// Header parser and byte classifier: turns file bytes into palette writes,
// pixel requests and errors. Depends on bmp8_pkg.
module bmp8_front #(
    parameter int MAX_WIDTH       = bmp8_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT      = bmp8_pkg::MaxHeightDef,
    parameter int PALETTE_ENTRIES = bmp8_pkg::PaletteDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  bmp8_pkg::t_in i_data,
    input  logic          i_transp,
    output logic          o_push,
    output bmp8_pkg::t_op o_op
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = $clog2(MAX_WIDTH + 4);
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam int PW = CW + 3;

    typedef enum logic [1:0] {
        PH_IDLE, PH_HEADER, PH_BODY, PH_DONE
    } t_phase;

    t_phase           r_phase;
    logic [31:0]      r_off;
    logic [31:0]      r_acc;
    logic [WW-1:0]    r_width;
    logic [HW-1:0]    r_height;
    logic             r_bottom_up;
    logic [CW-1:0]    r_cc;
    logic [31:0]      r_pdo;
    logic [23:0]      r_asm;
    logic [23:0]      r_zero;
    logic [SW-1:0]    r_col;
    logic [HW-1:0]    r_row;
    logic [SW-1:0]    r_stride;
    logic [WW+HW-1:0] r_area;

    t_phase        ph;
    logic [31:0]   off;
    logic [31:0]   n_acc;
    logic [31:0]   hmag;
    logic [CW-1:0] n_cc;
    logic [PW-1:0] pal_end;
    logic [PW-1:0] n_pal_end;
    logic [31:0]   rel;
    logic [23:0]   wcol;
    logic [HW-1:0] ypos;
    logic          last;
    logic [7:0]    b;

    always_comb begin
        b         = i_data.file_byte;
        ph        = i_data.first_byte ? PH_HEADER : r_phase;
        off       = i_data.first_byte ? 32'd0 : r_off;
        n_acc     = {b, (i_data.first_byte ? 24'd0 : r_acc[31:8])};
        hmag      = n_acc[31] ? (~n_acc + 32'd1) : n_acc;
        n_cc      = (n_acc > 32'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES) : n_acc[CW-1:0];
        pal_end   = PW'(bmp8_pkg::HeaderBytes) + {r_cc, 2'b00};
        n_pal_end = PW'(bmp8_pkg::HeaderBytes) + {n_cc, 2'b00};
        rel       = off - 32'(bmp8_pkg::HeaderBytes);
        wcol      = r_asm;
        if (rel[9:2] != 8'd0 && r_asm == r_zero) begin
            wcol = r_asm ^ 24'd1;
        end
        ypos = r_bottom_up ? (r_height - HW'(1) - r_row) : r_row;
        last = (r_row + HW'(1) == r_height) && (r_col + SW'(1) == SW'(r_width));

        o_push = 1'b0;
        o_op   = '0;
        if (i_accept && ph == PH_HEADER) begin
            o_op.kind = bmp8_pkg::OP_ERR;
            case (off)
                bmp8_pkg::OFF_SIG: begin
                    o_push = (n_acc[31:16] != bmp8_pkg::SIG_BM);
                    o_op.err = bmp8_pkg::ERR_SIG;
                end
                bmp8_pkg::OFF_HSIZE: begin
                    o_push = (n_acc != bmp8_pkg::INFO_SIZE);
                    o_op.err = bmp8_pkg::ERR_HSIZE;
                end
                bmp8_pkg::OFF_WIDTH: begin
                    o_push = n_acc[31] || n_acc == 32'd0 || n_acc > 32'(MAX_WIDTH);
                    o_op.err = bmp8_pkg::ERR_BOUNDS;
                end
                bmp8_pkg::OFF_HEIGHT: begin
                    o_push = hmag == 32'd0 || hmag > 32'(MAX_HEIGHT);
                    o_op.err = bmp8_pkg::ERR_BOUNDS;
                end
                bmp8_pkg::OFF_PLANES: begin
                    o_push = (n_acc[31:16] != 16'd1);
                    o_op.err = bmp8_pkg::ERR_PLANES;
                end
                bmp8_pkg::OFF_DEPTH: begin
                    o_push = (n_acc[31:16] != 16'd8);
                    o_op.err = bmp8_pkg::ERR_DEPTH;
                end
                bmp8_pkg::OFF_COMP: begin
                    o_push = (n_acc != 32'd0);
                    o_op.err = bmp8_pkg::ERR_COMP;
                end
                bmp8_pkg::OFF_ISIZE: begin
                    o_push = n_acc != 32'd0 && 64'(n_acc) != 64'(r_area);
                    o_op.err = bmp8_pkg::ERR_ISIZE;
                end
                bmp8_pkg::OFF_COLORS: begin
                    o_push = r_pdo < 32'(n_pal_end);
                    o_op.err = bmp8_pkg::ERR_BOUNDS;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end else if (i_accept && ph == PH_BODY) begin
            if (off < 32'(pal_end)) begin
                o_push     = (rel[1:0] == 2'd3);
                o_op.kind  = bmp8_pkg::OP_WR;
                o_op.idx   = rel[9:2];
                o_op.color = wcol;
            end else if (off >= r_pdo && r_col < SW'(r_width)) begin
                o_push      = 1'b1;
                o_op.kind   = bmp8_pkg::OP_PIX;
                o_op.idx    = b;
                o_op.loaded = 9'(b) < 9'(r_cc);
                o_op.x      = 12'(r_col);
                o_op.y      = 12'(ypos);
                o_op.alpha  = (i_transp && b == 8'd0) ? 8'h00 : 8'hff;
                o_op.last   = last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= (WW+HW)'(r_width) * (WW+HW)'(r_height);
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_off       <= '0;
            r_acc       <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_bottom_up <= 1'b0;
            r_cc        <= '0;
            r_pdo       <= '0;
            r_asm       <= '0;
            r_zero      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_stride    <= '0;
        end else if (i_accept) begin
            if (i_data.first_byte) begin
                r_phase     <= PH_HEADER;
                r_width     <= '0;
                r_height    <= '0;
                r_bottom_up <= 1'b0;
                r_cc        <= '0;
                r_pdo       <= '0;
                r_asm       <= '0;
                r_zero      <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_stride    <= '0;
            end
            if (ph == PH_HEADER || ph == PH_BODY) begin
                r_off <= (off == 32'hffff_ffff) ? off : off + 32'd1;
            end
            if (ph == PH_HEADER) begin
                r_acc <= n_acc;
                if (o_push) begin
                    r_phase <= PH_DONE;
                end else begin
                    case (off)
                        bmp8_pkg::OFF_DATA: r_pdo <= n_acc;
                        bmp8_pkg::OFF_WIDTH: begin
                            r_width  <= n_acc[WW-1:0];
                            r_stride <= (SW'(n_acc[WW-1:0]) + SW'(3)) & ~SW'(3);
                        end
                        bmp8_pkg::OFF_HEIGHT: begin
                            r_height    <= hmag[HW-1:0];
                            r_bottom_up <= ~n_acc[31];
                        end
                        bmp8_pkg::OFF_COLORS: r_cc <= n_cc;
                        bmp8_pkg::OFF_LAST: r_phase <= PH_BODY;
                        default: r_phase <= PH_HEADER;
                    endcase
                end
            end else if (ph == PH_BODY) begin
                if (off < 32'(pal_end)) begin
                    case (rel[1:0])
                        2'd0: r_asm <= {16'd0, b};
                        2'd1: r_asm[15:8] <= b;
                        2'd2: r_asm[23:16] <= b;
                        default: begin
                            if (rel[9:2] == 8'd0) begin
                                r_zero <= r_asm;
                            end
                        end
                    endcase
                end else if (off >= r_pdo) begin
                    if (o_push && last) begin
                        r_phase <= PH_DONE;
                    end
                    if (r_col + SW'(1) >= r_stride) begin
                        r_col <= '0;
                        r_row <= r_row + HW'(1);
                    end else begin
                        r_col <= r_col + SW'(1);
                    end
                end
            end
        end
    end
endmodule

### hdl/bmp8_back.sv
// Back end: writes the palette RAM, looks up pixel colours and holds the
// output register. Depends on bmp8_pkg and bmp8_ram.
module bmp8_back #(
    parameter int PALETTE_ENTRIES = bmp8_pkg::PaletteDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  bmp8_pkg::t_op  i_q_data,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output bmp8_pkg::t_out o_data
);
    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic           r_s1_v;
    bmp8_pkg::t_op  r_s1;
    logic           r_o_v;
    bmp8_pkg::t_out r_o;
    logic           ld_out;
    logic [23:0]    rdata;
    logic [23:0]    col;
    bmp8_pkg::t_out n_o;

    assign ld_out = r_s1_v && (!r_o_v || i_ready);
    assign o_pop  = i_q_valid && (!r_s1_v || ld_out);

    bmp8_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_pal (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_q_data.kind == bmp8_pkg::OP_WR),
        .i_waddr (i_q_data.idx[AW-1:0]),
        .i_wdata (i_q_data.color),
        .i_re    (o_pop && i_q_data.kind == bmp8_pkg::OP_PIX),
        .i_raddr (i_q_data.idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        col = r_s1.loaded ? rdata : 24'd0;
        n_o = '0;
        if (r_s1.kind == bmp8_pkg::OP_ERR) begin
            n_o.result_kind = bmp8_pkg::KIND_ERROR;
            n_o.error_code  = r_s1.err;
        end else begin
            n_o.result_kind = bmp8_pkg::KIND_PIXEL;
            n_o.pixel_x     = r_s1.x;
            n_o.pixel_y     = r_s1.y;
            n_o.red         = col[23:16];
            n_o.green       = col[15:8];
            n_o.blue        = col[7:0];
            n_o.alpha       = r_s1.alpha;
            n_o.last_pixel  = r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_v <= (i_q_data.kind != bmp8_pkg::OP_WR);
                r_s1   <= i_q_data;
            end else if (ld_out) begin
                r_s1_v <= 1'b0;
            end
            if (ld_out) begin
                r_o_v <= 1'b1;
                r_o   <= n_o;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o;
endmodule

### hdl/bmp8_palette_decoder.sv
// Top level of the 8-bit palettised BMP decoder.
// Depends on bmp8_pkg, bmp8_front, bmp8_queue, bmp8_back and bmp8_ram.
//
// Input channel: one file byte per transaction, first_byte set on byte 0
// of each file. Output channel: one pixel or error transaction.
// The front parser accepts a byte per cycle while the two-entry queue has
// room. Output valid follows the accepting edge through the queue, the
// palette RAM read and the output register. Sustained rate is one byte
// per cycle while the output receiver does not stall.
// A stalled receiver holds the output register; input ready drops once
// three more operations wait behind it, one in the lookup stage and two
// in the queue.
// Reset clears parser, queue and output state; the palette RAM is not
// cleared, each file reloads the entries it uses.
// Register 0 at address 0: bit 0 makes palette index 0 transparent.
module bmp8_palette_decoder #(
    parameter int MAX_WIDTH       = bmp8_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT      = bmp8_pkg::MaxHeightDef,
    parameter int PALETTE_ENTRIES = bmp8_pkg::PaletteDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bmp8_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bmp8_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic          r_transp;
    logic          accept;
    logic          push;
    bmp8_pkg::t_op op;
    logic          q_full;
    logic          q_valid;
    bmp8_pkg::t_op q_data;
    logic          pop;

    assign pready     = 1'b1;
    assign prdata     = (paddr == bmp8_pkg::REG_TRANSP) ? {31'd0, r_transp} : 32'd0;
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transp <= 1'b0;
        end else if (psel && penable && pwrite && paddr == bmp8_pkg::REG_TRANSP) begin
            r_transp <= pwdata[0];
        end
    end

    bmp8_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .i_transp (r_transp),
        .o_push   (push),
        .o_op     (op)
    );

    bmp8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    bmp8_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("operation queue overflow");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind |->
        o_out_data.alpha == 8'd0 && o_out_data.last_pixel == 1'b0)
        else $error("error transaction carries pixel fields");

    a_pixel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_kind |-> o_out_data.error_code == 3'd0)
        else $error("pixel transaction carries an error code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

### tb/tb_bmp8_palette_decoder.sv
// Self-checking testbench for bmp8_palette_decoder: streams BMP files, good, broken and truncated.
// Predicts pixels and errors with its own model of the parser; depends on bmp8_pkg and the RTL.
module tb_bmp8_palette_decoder;
    import bmp8_pkg::*;

    class pixel_scoreboard;
        bit          transp;
        int unsigned phase;
        int unsigned offs;
        logic [31:0] acc;
        int unsigned width, height, ncolors, data_off, col, row, stride;
        bit          bup;
        logic [23:0] pal [256];
        logic [23:0] entry, entry0;
        t_out        pending [$];
        int          errors;

        function void restart();
            phase = 1; offs = 0; acc = 0; width = 0; height = 0; bup = 0;
            ncolors = 0; data_off = 0; entry = 0; entry0 = 0; col = 0; row = 0; stride = 0;
        endfunction

        function void raise_error(logic [2:0] code);
            t_out r;
            r = '0;
            r.result_kind = KIND_ERROR;
            r.error_code = code;
            pending.push_back(r);
            phase = 3;
        endfunction

        function void header(int unsigned o);
            logic [31:0] a;
            a = acc;
            case (o)
                OFF_SIG:    if (a[31:16] != SIG_BM) raise_error(ERR_SIG);
                OFF_DATA:   data_off = a;
                OFF_HSIZE:  if (a != INFO_SIZE) raise_error(ERR_HSIZE);
                OFF_WIDTH: begin
                    if (a[31] || a == 0 || a > MaxWidthDef) raise_error(ERR_BOUNDS);
                    else begin
                        width = a;
                        stride = (a + 3) & ~32'd3;
                    end
                end
                OFF_HEIGHT: begin
                    bup = !a[31];
                    if (a[31]) a = -a;
                    if (a == 0 || a > MaxHeightDef) raise_error(ERR_BOUNDS);
                    else height = a;
                end
                OFF_PLANES: if (a[31:16] != 1) raise_error(ERR_PLANES);
                OFF_DEPTH:  if (a[31:16] != 8) raise_error(ERR_DEPTH);
                OFF_COMP:   if (a != 0) raise_error(ERR_COMP);
                OFF_ISIZE:  if (a != 0 && a != width * height) raise_error(ERR_ISIZE);
                OFF_COLORS: begin
                    ncolors = (a > PaletteDef) ? PaletteDef : a;
                    if (data_off < HeaderBytes + 4 * ncolors) raise_error(ERR_BOUNDS);
                end
                OFF_LAST:   phase = 2;
                default: ;
            endcase
        endfunction

        function void note_input(t_in d);
            int unsigned o, rel;
            t_out r;
            logic [7:0] b;
            logic [23:0] c;
            b = d.file_byte;
            if (d.first_byte) restart();
            if (phase != 1 && phase != 2) return;
            o = offs;
            if (offs != 32'hFFFF_FFFF) offs++;
            if (phase == 1) begin
                acc = {b, acc[31:8]};
                header(o);
            end else if (o < HeaderBytes + 4 * ncolors) begin
                rel = o - HeaderBytes;
                case (rel % 4)
                    0: entry = {16'h0, b};
                    1: entry[15:8] = b;
                    2: entry[23:16] = b;
                    default: begin
                        if (rel / 4 == 0) entry0 = entry;
                        else if (entry == entry0) entry[0] = ~entry[0];
                        pal[(rel / 4) % 256] = entry;
                    end
                endcase
            end else if (o >= data_off) begin
                if (col < width) begin
                    c = (b < ncolors) ? pal[b] : 24'h0;
                    r = '0;
                    r.result_kind = KIND_PIXEL;
                    r.pixel_x = col;
                    r.pixel_y = bup ? height - 1 - row : row;
                    {r.red, r.green, r.blue} = c;
                    r.alpha = (transp && b == 0) ? 8'h00 : 8'hFF;
                    r.last_pixel = (row + 1 == height) && (col + 1 == width);
                    pending.push_back(r);
                    if (r.last_pixel) phase = 3;
                end
                col++;
                if (col >= stride) begin
                    col = 0;
                    row++;
                end
            end
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t mismatch: expected %h, actual %h", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_in_valid, i_out_ready;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        o_in_ready, o_out_valid, pready;
    t_in         i_in_data;
    t_out        o_out_data;

    pixel_scoreboard sb;
    byte unsigned    file_bytes [$];
    int unsigned     cycles, burst_left, gap_left, sent;
    bit              stall_mode;

    bmp8_palette_decoder i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3_000_000) begin
            $display("bmp8_palette_decoder regression: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
        i_out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val; penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.transp = val[0];
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_byte(byte unsigned b, bit first);
        t_in d;
        d.file_byte = b;
        d.first_byte = first;
        if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 30);
        end
        if (gap_left > 0) i_in_valid <= 0;
        while (gap_left > 0) begin
            @(negedge i_clk);
            gap_left--;
        end
        i_in_valid <= 1;
        i_in_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(d);
        burst_left--;
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
    endtask

    task automatic keep_bytes(int n);
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
    endtask

    task automatic put32(int unsigned v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
        file_bytes.push_back(v[23:16]);
        file_bytes.push_back(v[31:24]);
    endtask

    // fault: 0 none, 1..7 error kinds; entry 1 randomly copies the entry 0 colour
    task automatic build_file(int w, int h, int ncol, int extra_off, int fault, bit sized,
                              bit garbage);
        int pad, doff, r, c, k;
        file_bytes.delete();
        doff = 54 + 4 * ((ncol > 256) ? 256 : ncol) + extra_off;
        if (fault == 7) doff = 54 + 4 * ncol - 1 - $urandom_range(0, 20);
        file_bytes.push_back(fault == 1 ? $urandom_range(0, 255) : 8'h42);
        file_bytes.push_back(fault == 1 ? 8'h4E : 8'h4D);
        put32($urandom);
        put32($urandom);
        put32(doff);
        put32(fault == 2 ? ($urandom_range(0, 1) ? 12 : $urandom) : 40);
        put32(w);
        put32(h);
        file_bytes.push_back(fault == 3 ? 8'h02 : 8'h01);
        file_bytes.push_back(fault == 3 ? $urandom_range(0, 255) : 8'h00);
        file_bytes.push_back(fault == 4 ? 8'h18 : 8'h08);
        file_bytes.push_back(fault == 4 ? $urandom_range(0, 255) : 8'h00);
        put32(fault == 5 ? $urandom_range(1, 3) : 0);
        put32(fault == 6 ? $urandom : (sized ? w * (h < 0 ? -h : h) : 0));
        put32($urandom);
        put32($urandom);
        put32(ncol);
        put32($urandom);
        for (k = 0; k < ((ncol > 256) ? 256 : ncol); k++) begin
            if (k == 1 && $urandom_range(0, 2) == 0) begin
                for (c = 0; c < 4; c++) file_bytes.push_back(file_bytes[54 + c]);
            end else put32($urandom);
        end
        for (k = 0; k < extra_off; k++) file_bytes.push_back($urandom);
        pad = ((w + 3) & ~3) - w;
        if (w > 0 && w <= 64 && h != 0 && (h < 0 ? -h : h) <= 64) begin
            for (r = 0; r < (h < 0 ? -h : h); r++) begin
                for (c = 0; c < w + pad; c++)
                    file_bytes.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
            end
        end
        if (garbage) for (k = 0; k < 6; k++) file_bytes.push_back($urandom);
    endtask

    task automatic drain();
        int unsigned t;
        t = 0;
        i_in_valid <= 0;
        while (sb.pending.size() != 0 && t < 100_000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_file();
        int w, h, sel;
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 5);
        if ($urandom_range(0, 1)) h = -h;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            build_file(w, h, $urandom_range(0, 12), $urandom_range(0, 3), 0,
                       $urandom_range(0, 1), $urandom_range(0, 1));
        else if (sel < 9) build_file(w, h, $urandom_range(1, 8), 0, $urandom_range(1, 7), 0, 0);
        else begin
            build_file(w, h, 4, 0, 0, 0, 0);
            repeat ($urandom_range(1, 40)) void'(file_bytes.pop_back());
        end
    endtask

    initial begin
        int n;
        int cut [1:7];
        cut = '{2, 18, 28, 30, 34, 38, 50};
        sb = new();
        sb.restart();
        sb.phase = 0;
        cycles = 0; burst_left = 0; gap_left = 0; stall_mode = 0; sent = 0;
        i_rst_n = 0; i_in_valid = 0; i_in_data = '0; i_out_ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        write_reg(REG_TRANSP, 32'd1);
        send_byte(8'hFF, 0);
        build_file(3, 2, 4, 0, 0, 1, 1); send_file();
        build_file(1, -1, 300, 2, 0, 0, 0); keep_bytes(52); send_file();
        build_file(4, -2, 0, 0, 0, 1, 0); send_file();
        for (n = 1; n <= 7; n++) begin
            build_file(2, 2, 2, 0, n, 0, 0); keep_bytes(cut[n]); send_file();
        end
        build_file(0, 1, 2, 0, 0, 0, 0); keep_bytes(22); send_file();
        build_file(4097, 1, 2, 0, 0, 0, 0); keep_bytes(22); send_file();
        build_file(-3, 1, 2, 0, 0, 0, 0); keep_bytes(22); send_file();
        build_file(2, 0, 2, 0, 0, 0, 0); keep_bytes(26); send_file();
        build_file(2, -4097, 2, 0, 0, 0, 0); keep_bytes(26); send_file();
        build_file(4096, 4096, 2, 0, 0, 0, 0); send_file();
        drain();
        write_reg(REG_TRANSP, {31'd0, 1'($urandom_range(0, 1))});

        while (sent < 650) begin
            random_file();
            send_file();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bmp8_palette_decoder regression: pass");
        else
            $display("bmp8_palette_decoder regression: fail");
        $finish;
    end
endmodule

### filelist.f
hdl/bmp8_pkg.sv
hdl/bmp8_ram.sv
hdl/bmp8_queue.sv
hdl/bmp8_front.sv
hdl/bmp8_back.sv
hdl/bmp8_palette_decoder.sv
tb/tb_bmp8_palette_decoder.sv
